>>> sv/lpmt_pkg.sv
package lpmt_pkg;

    localparam int DEF_PREFIX_BITS = 8;
    localparam int DEF_HOP_WIDTH   = 8;

    localparam int CMD_W = 2;
    localparam int LEN_W = 4;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef logic [CMD_W-1:0] cmd_t;

endpackage

>>> sv/longest_prefix_match_table.sv
// Lookup: accepted, then walks the trie levels (prefix length plus one, the
// length clamped to PREFIX_BITS), then a last state offers the result when the output can take it.
// Add and delete take the same walk and give no result.
// One item is in flight at a time; the single-port table read and the bitwise index walk set this.
// After reset the table is swept one entry per cycle over all 2^(PREFIX_BITS+1)-1 entries
// (511 by default), while no input beat is taken; the root then holds 1, all else 0.
module longest_prefix_match_table
    import lpmt_pkg::*;
#(
    parameter int PREFIX_BITS = DEF_PREFIX_BITS,
    parameter int HOP_WIDTH   = DEF_HOP_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CMD_W-1:0]       s_command,
    input  logic [PREFIX_BITS-1:0] s_prefix_bits,
    input  logic [LEN_W-1:0]       s_prefix_length,
    input  logic [HOP_WIDTH-1:0]   s_hop_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [HOP_WIDTH-1:0]   m_next_hop
);

    localparam int IDX_W       = PREFIX_BITS + 1;
    localparam int STORE_DEPTH = (2 ** (PREFIX_BITS + 1)) - 1;
    localparam int CNT_W       = $clog2(PREFIX_BITS + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_LAST  = 2'd3;

    logic [HOP_WIDTH-1:0] hop_mem [STORE_DEPTH];

    logic [1:0]             state_reg,   state_next;
    logic [IDX_W-1:0]       clr_idx_reg, clr_idx_next;
    cmd_t                   cmd_reg,     cmd_next;
    logic [PREFIX_BITS-1:0] bits_reg,    bits_next;
    logic [CNT_W-1:0]       cnt_reg,     cnt_next;
    logic [HOP_WIDTH-1:0]   hop_reg,     hop_next;
    logic [IDX_W-1:0]       idx_reg,     idx_next;
    logic [HOP_WIDTH-1:0]   best_reg,    best_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [HOP_WIDTH-1:0]   rd_data_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [HOP_WIDTH-1:0]   m_hop_reg,   m_hop_next;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [HOP_WIDTH-1:0] mem_wdata;
    logic                 mem_re;
    logic [HOP_WIDTH-1:0] fin_hop;
    logic                 out_load;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_next_hop = m_hop_reg;

    assign fin_hop  = (rd_valid_reg && (rd_data_reg != '0)) ? rd_data_reg : best_reg;
    assign out_load = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        cmd_next      = cmd_reg;
        bits_next     = bits_reg;
        cnt_next      = cnt_reg;
        hop_next      = hop_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        rd_valid_next = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_hop_next    = m_hop_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = '0;
        mem_re        = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = (clr_idx_reg == '0) ? HOP_WIDTH'(1) : '0;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(STORE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next  = s_command;
                    bits_next = s_prefix_bits;
                    hop_next  = s_hop_value;
                    idx_next  = '0;
                    best_next = '0;
                    if (int'(s_prefix_length) > PREFIX_BITS) begin
                        cnt_next = CNT_W'(PREFIX_BITS);
                    end else begin
                        cnt_next = CNT_W'(s_prefix_length);
                    end
                    if (s_command inside {CMD_ADD, CMD_DELETE, CMD_LOOKUP}) begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (rd_valid_reg && (rd_data_reg != '0)) begin
                    best_next = rd_data_reg;
                end
                if (cmd_reg == CMD_LOOKUP) begin
                    mem_re        = 1'b1;
                    rd_valid_next = 1'b1;
                end
                if (cnt_reg == '0) begin
                    if (cmd_reg == CMD_LOOKUP) begin
                        state_next = ST_LAST;
                    end else begin
                        mem_we     = 1'b1;
                        mem_wdata  = (cmd_reg == CMD_ADD) ? hop_reg : '0;
                        state_next = ST_IDLE;
                    end
                end else begin
                    idx_next  = (idx_reg << 1) + IDX_W'(1) + IDX_W'(bits_reg[PREFIX_BITS-1]);
                    bits_next = bits_reg << 1;
                    cnt_next  = cnt_reg - CNT_W'(1);
                end
            end
            ST_LAST: begin
                best_next = fin_hop;
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_hop_next   = fin_hop;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hop_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= hop_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        bits_reg  <= bits_next;
        cnt_reg   <= cnt_next;
        hop_reg   <= hop_next;
        idx_reg   <= idx_next;
        best_reg  <= best_next;
        m_hop_reg <= m_hop_next;
    end

endmodule

>>> tb/tb_longest_prefix_match_table.sv
module tb_longest_prefix_match_table
    import lpmt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB = DEF_PREFIX_BITS;
    localparam int HW = DEF_HOP_WIDTH;
    localparam int DEPTH = (2 << PB) - 1;
    localparam int RANDOM_ITEMS = 1030;
    localparam int QUIET_TAIL = 150;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 3000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    cmd_t          s_command = CMD_ADD;
    logic [PB-1:0] s_prefix_bits = '0;
    logic [LEN_W-1:0] s_prefix_length = '0;
    logic [HW-1:0] s_hop_value = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [HW-1:0] m_next_hop;

    typedef struct packed {
        cmd_t             cmd;
        logic [PB-1:0]    bits;
        logic [LEN_W-1:0] len;
        logic [HW-1:0]    hop;
        logic             typed;
        logic [HW-1:0]    want;
    } plan_row_t;

    logic [HW-1:0] route_hops [DEPTH];
    logic [HW-1:0] next_hop_q [$];
    logic [HW-1:0] want_hop;

    int  fails = 0;
    int  n_add = 0;
    int  n_del = 0;
    int  n_lookup = 0;
    int  n_unused = 0;
    int  n_results = 0;
    int  idle_cycles = 0;
    bit  idling = 1'b1;
    bit  hold_rx = 1'b0;
    bit  hold_done = 1'b0;

    longest_prefix_match_table dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_prefix_bits  (s_prefix_bits),
        .s_prefix_length(s_prefix_length),
        .s_hop_value    (s_hop_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_hop     (m_next_hop)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int node_at(input logic [PB-1:0] bits, input int len);
        return ((1 << len) - 1) + (int'(bits) >> (PB - len));
    endfunction

    // Updates the local route table and returns 1 when the beat yields a next hop.
    function automatic bit route_step(input cmd_t cmd, input logic [PB-1:0] bits,
                                      input logic [LEN_W-1:0] len_in,
                                      input logic [HW-1:0] hop,
                                      output logic [HW-1:0] hop_out);
        int len;
        logic [HW-1:0] best;
        len = (len_in > PB) ? PB : int'(len_in);
        hop_out = '0;
        case (cmd)
            CMD_ADD: begin
                route_hops[node_at(bits, len)] = hop;
                return 1'b0;
            end
            CMD_DELETE: begin
                route_hops[node_at(bits, len)] = '0;
                return 1'b0;
            end
            CMD_LOOKUP: begin
                best = route_hops[0];
                for (int lvl = 1; lvl <= len; lvl++) begin
                    if (route_hops[node_at(bits, lvl)] != '0) begin
                        best = route_hops[node_at(bits, lvl)];
                    end
                end
                hop_out = best;
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    task automatic send_beat(input cmd_t cmd, input logic [PB-1:0] bits,
                             input logic [LEN_W-1:0] len, input logic [HW-1:0] hop,
                             input bit typed, input logic [HW-1:0] want);
        logic [HW-1:0] predicted;
        bit has_result;
        if (idling && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_prefix_bits <= bits;
        s_prefix_length <= len;
        s_hop_value <= hop;
        do @(posedge aclk); while (!s_ready);
        has_result = route_step(cmd, bits, len, hop, predicted);
        if (has_result) begin
            next_hop_q.push_back(typed ? want : predicted);
        end
        case (cmd)
            CMD_ADD:    n_add++;
            CMD_DELETE: n_del++;
            CMD_LOOKUP: n_lookup++;
            default:    n_unused++;
        endcase
        @(negedge aclk);
    endtask

    initial begin
        plan_row_t plan [22];
        logic [PB-1:0] hot [8];
        logic [PB-1:0] bits;
        logic [LEN_W-1:0] len;
        logic [HW-1:0] hop;
        cmd_t cmd;
        int pick;
        int counted;

        plan = '{
            '{CMD_LOOKUP, 8'h00, 4'd0,  8'h00, 1'b1, 8'h01},
            '{CMD_LOOKUP, 8'hff, 4'd8,  8'h00, 1'b1, 8'h01},
            '{CMD_LOOKUP, 8'h00, 4'd15, 8'hff, 1'b1, 8'h01},
            '{CMD_ADD,    8'h80, 4'd1,  8'hff, 1'b0, 8'h00},
            '{CMD_LOOKUP, 8'hff, 4'd8,  8'h00, 1'b1, 8'hff},
            '{CMD_LOOKUP, 8'h7f, 4'd8,  8'h00, 1'b1, 8'h01},
            '{CMD_ADD,    8'hff, 4'd8,  8'h55, 1'b0, 8'h00},
            '{CMD_LOOKUP, 8'hff, 4'd15, 8'h00, 1'b0, 8'h00},
            '{CMD_ADD,    8'haa, 4'd15, 8'h01, 1'b0, 8'h00},
            '{CMD_LOOKUP, 8'haa, 4'd8,  8'h00, 1'b0, 8'h00},
            '{CMD_ADD,    8'h80, 4'd1,  8'h00, 1'b0, 8'h00},
            '{CMD_LOOKUP, 8'hff, 4'd7,  8'h00, 1'b0, 8'h00},
            '{CMD_DELETE, 8'h12, 4'd4,  8'h00, 1'b0, 8'h00},
            '{CMD_UNUSED, 8'hff, 4'd8,  8'hff, 1'b0, 8'h00},
            '{CMD_LOOKUP, 8'hff, 4'd8,  8'h00, 1'b0, 8'h00},
            '{CMD_DELETE, 8'h00, 4'd0,  8'h00, 1'b0, 8'h00},
            '{CMD_LOOKUP, 8'h00, 4'd0,  8'h00, 1'b1, 8'h00},
            '{CMD_LOOKUP, 8'h55, 4'd8,  8'h00, 1'b1, 8'h00},
            '{CMD_ADD,    8'h00, 4'd0,  8'h80, 1'b0, 8'h00},
            '{CMD_ADD,    8'h00, 4'd8,  8'hff, 1'b0, 8'h00},
            '{CMD_LOOKUP, 8'h00, 4'd8,  8'h00, 1'b0, 8'h00},
            '{CMD_LOOKUP, 8'h01, 4'd8,  8'h00, 1'b0, 8'h00}
        };

        for (int i = 0; i < DEPTH; i++) begin
            route_hops[i] = '0;
        end
        route_hops[0] = 8'h01;
        for (int i = 0; i < 8; i++) begin
            hot[i] = PB'($urandom);
        end

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            send_beat(plan[i].cmd, plan[i].bits, plan[i].len, plan[i].hop,
                      plan[i].typed, plan[i].want);
        end

        // Most beats reuse a few hot prefixes so that lookups walk populated paths.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            idling = (counted < RANDOM_ITEMS - QUIET_TAIL) && ((counted / 120) % 3 != 2);
            if (counted == 300) begin
                hold_rx = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                cmd = CMD_LOOKUP;
            end else if (pick < 75) begin
                cmd = CMD_ADD;
            end else if (pick < 93) begin
                cmd = CMD_DELETE;
            end else begin
                cmd = CMD_UNUSED;
            end
            if ($urandom_range(0, 3) != 0) begin
                bits = hot[$urandom_range(0, 7)] ^ (PB'($urandom) >> $urandom_range(1, 8));
            end else begin
                bits = PB'($urandom);
            end
            len = ($urandom_range(0, 9) != 0) ? LEN_W'($urandom_range(0, PB))
                                              : LEN_W'($urandom_range(PB + 1, 15));
            hop = ($urandom_range(0, 9) != 0) ? HW'($urandom) : '0;
            send_beat(cmd, bits, len, hop, 1'b0, '0);
            counted++;
        end
        s_valid <= 1'b0;

        while (next_hop_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Covered %0d adds, %0d deletes, %0d lookups and %0d unused commands;",
                 n_add, n_del, n_lookup, n_unused);
        $display("%0d next hop beats checked, %0d mismatches.", n_results, fails);
        if (fails == 0 && next_hop_q.size() == 0) begin
            $display("tb_longest_prefix_match_table OK");
        end else begin
            $display("tb_longest_prefix_match_table NOT OK");
        end
        $finish;
    end

    initial begin
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_rx && !hold_done) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (next_hop_q.size() == 0) begin
                fails++;
                $display("%0t: unexpected next hop beat, expected none, got %02h",
                         $realtime, m_next_hop);
            end else begin
                want_hop = next_hop_q.pop_front();
                if (m_next_hop !== want_hop) begin
                    fails++;
                    $display("%0t: next_hop mismatch, expected %02h, got %02h",
                             $realtime, want_hop, m_next_hop);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $realtime, STALL_LIMIT);
            $display("tb_longest_prefix_match_table NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> sim.f
sv/lpmt_pkg.sv
sv/longest_prefix_match_table.sv
tb/tb_longest_prefix_match_table.sv
